// ----- sv/pixel_hsl_shift_core_defines.svh -----
// Assertion macros for the pixel HSL shift core.
`ifndef PIXEL_HSL_SHIFT_CORE_DEFINES_SVH
`define PIXEL_HSL_SHIFT_CORE_DEFINES_SVH

// same-cycle implication
`define PHSL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PHSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/phsl_pkg.sv -----
package phsl_pkg;

   localparam int unsigned ChanWidth     = 8;
   localparam int unsigned ChanCount     = 3;
   localparam int unsigned QuotWidth     = 8;
   localparam int unsigned QuotIdxWidth  = $clog2(QuotWidth);
   localparam int unsigned DivSteps      = 2;
   localparam int unsigned DivStages     = QuotWidth / DivSteps;
   localparam int unsigned FwdStages     = 2;
   localparam int unsigned BackStages    = 5;
   localparam int unsigned PipeDepth     = FwdStages + DivStages + BackStages;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 9;
   localparam int unsigned HueNumWidth   = 14;
   localparam int unsigned HueDenWidth   = 8;
   localparam int unsigned SatNumWidth   = 16;
   localparam int unsigned SatDenWidth   = 10;

   localparam logic [7:0]  HueScale     = 8'd43;
   localparam logic [7:0]  HueGreenBase = 8'd85;
   localparam logic [7:0]  HueBlueBase  = 8'd171;
   localparam logic [7:0]  SatScale     = 8'd255;
   localparam logic [9:0]  SatSpan      = 10'd512;
   localparam logic [7:0]  LightMid     = 8'd128;
   localparam logic [7:0]  ChanMax      = 8'd255;
   localparam logic [8:0]  WeightFull   = 9'd256;
   // ceil(2^24 / 43): x*256/43 == (x*WeightRecip) >> 16 for x < 43
   localparam logic [18:0] WeightRecip  = 19'd390168;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } phsl_sector_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_HUE_OFFSET,
      CSR_SAT_OFFSET,
      CSR_LIGHT_OFFSET
   } phsl_csr_index_type;

   typedef struct packed {
      logic [7:0]        hue_offset;
      logic signed [8:0] sat_offset;
      logic signed [8:0] light_offset;
   } phsl_cfg_type;

   typedef struct packed {
      phsl_sector_type sector;
      logic            neg;
      logic            grey;
      logic            sat_en;
      logic [7:0]      light;
   } phsl_side_type;

   typedef struct packed {
      logic [HueNumWidth-1:0] num_h;
      logic [HueDenWidth-1:0] den_h;
      logic [SatNumWidth-1:0] num_s;
      logic [SatDenWidth-1:0] den_s;
   } phsl_div_op_type;

   // hue sector weight: x*256/43 truncated, capped at 256
   function automatic logic [8:0] phsl_weight(input logic [6:0] x);
      logic [25:0] prod;
      prod = 26'(x) * 26'(WeightRecip);
      if (x >= 7'(HueScale)) return WeightFull;
      return {1'b0, prod[23:16]};
   endfunction

endpackage

// ----- sv/phsl_fwd.sv -----
module phsl_fwd (
   input  logic                               clock,
   input  logic [phsl_pkg::FwdStages-1:0]     en,
   input  logic [phsl_pkg::ChanWidth-1:0]     red,
   input  logic [phsl_pkg::ChanWidth-1:0]     green,
   input  logic [phsl_pkg::ChanWidth-1:0]     blue,
   output phsl_pkg::phsl_div_op_type          oper,
   output phsl_pkg::phsl_side_type            side
);

   logic [7:0]                mx_in, mn_in, mx_ff, mn_ff;
   phsl_pkg::phsl_sector_type sector_in, sector_ff;
   logic signed [8:0]         diff_in, diff_ff;

   always_comb begin
      mx_in = (green > red) ? green : red;
      if (blue > mx_in) mx_in = blue;
      mn_in = (green < red) ? green : red;
      if (blue < mn_in) mn_in = blue;
      priority if (mx_in == red) begin
         sector_in = phsl_pkg::SECTOR_RED;
         diff_in   = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (mx_in == green) begin
         sector_in = phsl_pkg::SECTOR_GREEN;
         diff_in   = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         sector_in = phsl_pkg::SECTOR_BLUE;
         diff_in   = $signed({1'b0, red}) - $signed({1'b0, green});
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mx_ff     <= mx_in;
         mn_ff     <= mn_in;
         sector_ff <= sector_in;
         diff_ff   <= diff_in;
      end
   end

   logic [7:0]                  delta, light, mag;
   logic [8:0]                  sum;
   phsl_pkg::phsl_div_op_type   oper_in, oper_ff;
   phsl_pkg::phsl_side_type     side_in, side_ff;

   always_comb begin
      delta = mx_ff - mn_ff;
      sum   = {1'b0, mx_ff} + {1'b0, mn_ff};
      light = sum[8:1];
      mag   = diff_ff[8] ? 8'(9'd0 - diff_ff) : diff_ff[7:0];

      oper_in.num_h = phsl_pkg::HueNumWidth'(mag) * phsl_pkg::HueNumWidth'(phsl_pkg::HueScale);
      oper_in.den_h = delta;
      oper_in.num_s = phsl_pkg::SatNumWidth'(delta)
                    * phsl_pkg::SatNumWidth'(phsl_pkg::SatScale);
      oper_in.den_s = (light > phsl_pkg::LightMid)
                    ? phsl_pkg::SatSpan - phsl_pkg::SatDenWidth'(delta)
                    : phsl_pkg::SatDenWidth'(sum);

      side_in.sector = sector_ff;
      side_in.neg    = diff_ff[8];
      side_in.grey   = (delta == 8'd0);
      side_in.sat_en = (light != 8'd0) && (light != phsl_pkg::ChanMax);
      side_in.light  = light;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         oper_ff <= oper_in;
         side_ff <= side_in;
      end
   end

   assign oper = oper_ff;
   assign side = side_ff;

endmodule

// ----- sv/phsl_div.sv -----
module phsl_div (
   input  logic                                clock,
   input  logic [phsl_pkg::DivStages-1:0]      en,
   input  phsl_pkg::phsl_div_op_type           oper,
   input  phsl_pkg::phsl_side_type             up_side,
   output logic [phsl_pkg::QuotWidth-1:0]      hue_quot,
   output logic [phsl_pkg::QuotWidth-1:0]      sat_quot,
   output phsl_pkg::phsl_side_type             side
);

   localparam int unsigned Stages   = phsl_pkg::DivStages;
   localparam int unsigned QW       = phsl_pkg::QuotWidth;
   localparam int unsigned QiW      = phsl_pkg::QuotIdxWidth;
   localparam int unsigned HueNumW  = phsl_pkg::HueNumWidth;
   localparam int unsigned SatNumW  = phsl_pkg::SatNumWidth;
   localparam int unsigned HueTrW   = phsl_pkg::HueDenWidth + QW - 1;
   localparam int unsigned SatTrW   = phsl_pkg::SatDenWidth + QW - 1;

   phsl_pkg::phsl_div_op_type oper_src [Stages];
   phsl_pkg::phsl_div_op_type oper_in  [Stages];
   phsl_pkg::phsl_div_op_type oper_ff  [Stages];
   logic [QW-1:0]             hq_src [Stages], hq_in [Stages], hq_ff [Stages];
   logic [QW-1:0]             sq_src [Stages], sq_in [Stages], sq_ff [Stages];
   phsl_pkg::phsl_side_type   side_src [Stages], side_ff [Stages];

   always_comb begin
      oper_src[0] = oper;
      hq_src[0]   = '0;
      sq_src[0]   = '0;
      side_src[0] = up_side;
      for (int g = 1; g < Stages; g++) begin
         oper_src[g] = oper_ff[g-1];
         hq_src[g]   = hq_ff[g-1];
         sq_src[g]   = sq_ff[g-1];
         side_src[g] = side_ff[g-1];
      end
   end

   // restoring division, DivSteps quotient bits per stage, MSB first
   always_comb begin
      phsl_pkg::phsl_div_op_type work;
      logic [QW-1:0]     hq, sq;
      logic [QiW-1:0]    pos;
      logic [HueTrW-1:0] hue_trial;
      logic [SatTrW-1:0] sat_trial;
      for (int g = 0; g < Stages; g++) begin
         work = oper_src[g];
         hq   = hq_src[g];
         sq   = sq_src[g];
         for (int j = 0; j < phsl_pkg::DivSteps; j++) begin
            pos       = QiW'(QW - 1 - g * phsl_pkg::DivSteps - j);
            hue_trial = HueTrW'(work.den_h) << pos;
            sat_trial = SatTrW'(work.den_s) << pos;
            if (HueTrW'(work.num_h) >= hue_trial) begin
               work.num_h = work.num_h - HueNumW'(hue_trial);
               hq[pos]    = 1'b1;
            end
            if (SatTrW'(work.num_s) >= sat_trial) begin
               work.num_s = work.num_s - SatNumW'(sat_trial);
               sq[pos]    = 1'b1;
            end
         end
         oper_in[g] = work;
         hq_in[g]   = hq;
         sq_in[g]   = sq;
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < Stages; g++) begin
         if (en[g]) begin
            oper_ff[g] <= oper_in[g];
            hq_ff[g]   <= hq_in[g];
            sq_ff[g]   <= sq_in[g];
            side_ff[g] <= side_src[g];
         end
      end
   end

   assign hue_quot = hq_ff[Stages-1];
   assign sat_quot = sq_ff[Stages-1];
   assign side     = side_ff[Stages-1];

endmodule

// ----- sv/phsl_back.sv -----
module phsl_back (
   input  logic                               clock,
   input  logic [phsl_pkg::BackStages-1:0]    en,
   input  phsl_pkg::phsl_cfg_type             cfg,
   input  logic [phsl_pkg::QuotWidth-1:0]     hue_quot,
   input  logic [phsl_pkg::QuotWidth-1:0]     sat_quot,
   input  phsl_pkg::phsl_side_type            side,
   output logic [phsl_pkg::ChanWidth-1:0]     red,
   output logic [phsl_pkg::ChanWidth-1:0]     green,
   output logic [phsl_pkg::ChanWidth-1:0]     blue
);

   localparam int unsigned Chans = phsl_pkg::ChanCount;

   function automatic logic [7:0] clamp_chan(input logic signed [9:0] v);
      if (v < 10'sd0) return 8'd0;
      if (v > 10'sd255) return 8'hFF;
      return v[7:0];
   endfunction

   // stage 1: hue assembly and rotation, offset clamps
   logic [7:0]        hue_base, hue_mag, hue_raw, sat_raw;
   logic [7:0]        hue_in, sat1_in, light1_in;
   logic [7:0]        hue_ff, sat1_ff, light1_ff;

   always_comb begin
      unique case (side.sector)
         phsl_pkg::SECTOR_RED:   hue_base = 8'd0;
         phsl_pkg::SECTOR_GREEN: hue_base = phsl_pkg::HueGreenBase;
         phsl_pkg::SECTOR_BLUE:  hue_base = phsl_pkg::HueBlueBase;
         default:                hue_base = 8'd0;
      endcase
      hue_mag   = side.neg ? 8'd0 - hue_quot : hue_quot;
      hue_raw   = side.grey ? 8'd0 : hue_base + hue_mag;
      hue_in    = hue_raw + cfg.hue_offset;
      sat_raw   = side.sat_en ? sat_quot : 8'd0;
      sat1_in   = clamp_chan($signed({2'b00, sat_raw}) + 10'(cfg.sat_offset));
      light1_in = clamp_chan($signed({2'b00, side.light}) + 10'(cfg.light_offset));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hue_ff    <= hue_in;
         sat1_ff   <= sat1_in;
         light1_ff <= light1_in;
      end
   end

   // stage 2: per-channel weights from hue sector
   logic [8:0] w_in [Chans], w_ff [Chans];
   logic [7:0] sat2_ff, light2_ff;

   always_comb begin
      priority if (hue_ff < phsl_pkg::HueGreenBase) begin
         w_in[0] = phsl_pkg::phsl_weight(7'(phsl_pkg::HueGreenBase - hue_ff));
         w_in[1] = phsl_pkg::phsl_weight(7'(hue_ff));
         w_in[2] = 9'd0;
      end else if (hue_ff < phsl_pkg::HueBlueBase) begin
         w_in[0] = 9'd0;
         w_in[1] = phsl_pkg::phsl_weight(7'(phsl_pkg::HueBlueBase - hue_ff));
         w_in[2] = phsl_pkg::phsl_weight(7'(hue_ff - phsl_pkg::HueGreenBase));
      end else begin
         w_in[0] = phsl_pkg::phsl_weight(7'(hue_ff - phsl_pkg::HueBlueBase));
         w_in[1] = 9'd0;
         w_in[2] = phsl_pkg::phsl_weight(7'(8'd0 - hue_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         w_ff      <= w_in;
         sat2_ff   <= sat1_ff;
         light2_ff <= light1_ff;
      end
   end

   // stage 3: S*w/256
   logic [16:0] sw [Chans];
   logic [7:0]  p_ff [Chans];
   logic [7:0]  sat3_ff, light3_ff;

   always_comb begin
      for (int c = 0; c < Chans; c++) begin
         sw[c] = 17'(sat2_ff) * 17'(w_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int c = 0; c < Chans; c++) p_ff[c] <= sw[c][15:8];
         sat3_ff   <= sat2_ff;
         light3_ff <= light2_ff;
      end
   end

   // stage 4: t and lightness scale product
   logic [9:0]  t [Chans];
   logic [16:0] mt [Chans];
   logic [7:0]  scale_in, scale_ff;
   logic [7:0]  mt_ff [Chans];
   logic        upper_ff;

   always_comb begin
      scale_in = (light3_ff < phsl_pkg::LightMid) ? light3_ff
               : 8'(9'd256 - {1'b0, light3_ff});
      for (int c = 0; c < Chans; c++) begin
         t[c]  = {1'b0, p_ff[c], 1'b0} + 10'(phsl_pkg::WeightFull) - 10'(sat3_ff);
         mt[c] = 17'(scale_in) * 17'(t[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int c = 0; c < Chans; c++) mt_ff[c] <= mt[c][15:8];
         scale_ff <= scale_in;
         upper_ff <= !(light3_ff < phsl_pkg::LightMid);
      end
   end

   // stage 5: upper half subtracts 2*(256-L), kept mod 256
   logic [7:0] out_in [Chans], out_ff [Chans];

   always_comb begin
      for (int c = 0; c < Chans; c++) begin
         out_in[c] = mt_ff[c] - (upper_ff ? {scale_ff[6:0], 1'b0} : 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         out_ff <= out_in;
      end
   end

   assign red   = out_ff[0];
   assign green = out_ff[1];
   assign blue  = out_ff[2];

endmodule

// ----- sv/pixel_hsl_shift_core.sv -----
// Channel  Dir  Handshake                 Beat payload
// req      in   req_valid / req_stall     req_red_in, req_green_in, req_blue_in
// rsp      out  rsp_valid / rsp_stall     rsp_red_out, rsp_green_out, rsp_blue_out
// csr      in   csr_write_enable          csr_index, csr_write_data
//
// One pixel per cycle sustained while rsp is not stalled; 11 register stages
// (2 front, 4 divider at 2 quotient bits each, 5 back).
// The hue and saturation divider is radix-4.
// Synchronous reset clears the stage valid bits and the three offsets.
// A stalled rsp beat holds; upstream stages keep filling bubbles, so req
// is taken until all 11 stages hold a beat.
module pixel_hsl_shift_core (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [phsl_pkg::ChanWidth-1:0]       req_red_in,
   input  logic [phsl_pkg::ChanWidth-1:0]       req_green_in,
   input  logic [phsl_pkg::ChanWidth-1:0]       req_blue_in,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [phsl_pkg::ChanWidth-1:0]       rsp_red_out,
   output logic [phsl_pkg::ChanWidth-1:0]       rsp_green_out,
   output logic [phsl_pkg::ChanWidth-1:0]       rsp_blue_out,

   input  logic                                 csr_write_enable,
   input  logic [phsl_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [phsl_pkg::CsrDataWidth-1:0]    csr_write_data
);

   localparam int unsigned Depth = phsl_pkg::PipeDepth;
   localparam int unsigned DivLo = phsl_pkg::FwdStages;
   localparam int unsigned BckLo = phsl_pkg::FwdStages + phsl_pkg::DivStages;

   phsl_pkg::phsl_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            phsl_pkg::CSR_HUE_OFFSET:   cfg_ff.hue_offset   <= csr_write_data[7:0];
            phsl_pkg::CSR_SAT_OFFSET:   cfg_ff.sat_offset   <= csr_write_data;
            phsl_pkg::CSR_LIGHT_OFFSET: cfg_ff.light_offset <= csr_write_data;
            default: ;
         endcase
      end
   end

   // stage k loads when empty or when its beat moves on
   logic [Depth-1:0] stage_en, valid_in, valid_ff;

   always_comb begin
      stage_en[Depth-1] = !valid_ff[Depth-1] || !rsp_stall;
      for (int k = Depth - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < Depth; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !stage_en[0];
   assign rsp_valid = valid_ff[Depth-1];

   phsl_pkg::phsl_div_op_type              fwd_oper;
   phsl_pkg::phsl_side_type                fwd_side, div_side;
   logic [phsl_pkg::QuotWidth-1:0]         hue_quot, sat_quot;

   phsl_fwd u_fwd (
      .clock (clock),
      .en    (stage_en[DivLo-1:0]),
      .red   (req_red_in),
      .green (req_green_in),
      .blue  (req_blue_in),
      .oper  (fwd_oper),
      .side  (fwd_side)
   );

   phsl_div u_div (
      .clock    (clock),
      .en       (stage_en[BckLo-1:DivLo]),
      .oper     (fwd_oper),
      .up_side  (fwd_side),
      .hue_quot (hue_quot),
      .sat_quot (sat_quot),
      .side     (div_side)
   );

   phsl_back u_back (
      .clock    (clock),
      .en       (stage_en[Depth-1:BckLo]),
      .cfg      (cfg_ff),
      .hue_quot (hue_quot),
      .sat_quot (sat_quot),
      .side     (div_side),
      .red      (rsp_red_out),
      .green    (rsp_green_out),
      .blue     (rsp_blue_out)
   );

endmodule

// ----- sv/phsl_checker.sv -----
`include "pixel_hsl_shift_core_defines.svh"

module phsl_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [phsl_pkg::ChanWidth-1:0]       rsp_red_out,
   input logic [phsl_pkg::ChanWidth-1:0]       rsp_green_out,
   input logic [phsl_pkg::ChanWidth-1:0]       rsp_blue_out
);

   localparam int unsigned OccW = $clog2(phsl_pkg::PipeDepth + 1);

   // beats taken but not yet delivered
   logic [OccW-1:0] occ_in, occ_ff;

   always_comb begin
      occ_in = occ_ff;
      if (req_valid && !req_stall) occ_in = occ_in + 1'b1;
      if (rsp_valid && !rsp_stall) occ_in = occ_in - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   `PHSL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_red_out) && $stable(rsp_green_out) && $stable(rsp_blue_out), "stalled rsp beat changed")
   `PHSL_ASSERT_IMPLY(a_drain_ready, clock, reset, !rsp_valid || !rsp_stall, !req_stall, "req stalled while rsp side drains")
   `PHSL_ASSERT_IMPLY(a_no_phantom, clock, reset, rsp_valid, occ_ff != '0, "rsp beat without a pending req beat")
   `PHSL_ASSERT_IMPLY(a_occ_bound, clock, reset, 1'b1, occ_ff <= OccW'(phsl_pkg::PipeDepth), "more beats in flight than stages")

endmodule

bind pixel_hsl_shift_core phsl_checker u_phsl_checker (.*);
